// ===== rtl/tmcw_pkg.sv =====
// Shared constants, codes and types of the text-mode console writer.
package tmcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int SWP_W  = $clog2(CELL_COUNT + 1);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);

  localparam int OP_W      = 2;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 8;
  localparam int INDEX_W   = 11;
  localparam int CELL_W    = 16;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'd13;

  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_NEWLINE,
    CMD_RETURN,
    CMD_CLEAR,
    CMD_READ,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [CELL_W-1:0]   glyph;
    logic [ADDR_W-1:0]   index;
    logic                index_ok;
  } cmd_t;

  typedef struct packed {
    logic init_done;
  } back_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SWEEP,
    BK_READ
  } back_state_t;

endpackage

// ===== rtl/tmcw_if.sv =====
// Valid/ready channel interfaces for the console writer's input and result transactions.
interface tmcw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  char_code;
  logic [7:0]  color;
  logic [10:0] cell_index;

  modport source (output valid, operation, char_code, color, cell_index, input ready);
  modport sink   (input valid, operation, char_code, color, cell_index, output ready);
endinterface

interface tmcw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_data;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_column;

  modport source (output valid, cell_data, cursor_row, cursor_column, input ready);
  modport sink   (input valid, cell_data, cursor_row, cursor_column, output ready);
endinterface

// ===== rtl/tmcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tmcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tmcw_front.sv =====
// Front end: accept input transactions and classify them into commands.
module tmcw_front (
  tmcw_in_if.sink               in_txn,
  input  tmcw_pkg::back_status_t status,
  input  logic                  q_full,
  output logic                  push,
  output tmcw_pkg::cmd_t        push_cmd
);
  import tmcw_pkg::*;

  assign in_txn.ready = ~q_full & status.init_done;
  assign push         = in_txn.valid & in_txn.ready;

  always_comb begin
    push_cmd.glyph    = {in_txn.color, in_txn.char_code};
    push_cmd.index    = ADDR_W'(in_txn.cell_index);
    push_cmd.index_ok = (32'(in_txn.cell_index) < CELL_COUNT);
    unique case (in_txn.operation)
      OP_PUT: begin
        if (in_txn.char_code == CHAR_NEWLINE) begin
          push_cmd.kind = CMD_NEWLINE;
        end else if (in_txn.char_code == CHAR_RETURN) begin
          push_cmd.kind = CMD_RETURN;
        end else begin
          push_cmd.kind = CMD_PUT;
        end
      end
      OP_CLEAR: push_cmd.kind = CMD_CLEAR;
      OP_READ:  push_cmd.kind = CMD_READ;
      default:  push_cmd.kind = CMD_NOP;
    endcase
  end

endmodule

// ===== rtl/tmcw_queue.sv =====
// Short command queue between the front end and the back end.
module tmcw_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tmcw_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output tmcw_pkg::cmd_t pop_cmd,
  output logic           empty
);
  import tmcw_pkg::*;

  cmd_t              entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/tmcw_back.sv =====
// Back end: execute commands on the screen memory and cursor, and hold the result.
module tmcw_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tmcw_pkg::cmd_t             cmd,
  input  logic                       q_empty,
  output logic                       pop,
  output tmcw_pkg::back_status_t     status,
  output logic                       ram_we,
  output logic [tmcw_pkg::ADDR_W-1:0] ram_waddr,
  output logic [tmcw_pkg::CELL_W-1:0] ram_wdata,
  output logic [tmcw_pkg::ADDR_W-1:0] ram_raddr,
  input  logic [tmcw_pkg::CELL_W-1:0] ram_rdata,
  tmcw_out_if.source                 out_txn
);
  import tmcw_pkg::*;

  back_state_t       state_r, state_nxt;
  logic [SWP_W-1:0]  sweep_r, sweep_nxt;
  logic              zero_mode_r, zero_mode_nxt;
  logic              report_r, report_nxt;
  logic              init_done_r, init_done_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic              out_valid_r;
  logic [CELL_W-1:0] out_data_r;
  logic [ROW_OUT_W-1:0] out_row_r;
  logic [COL_OUT_W-1:0] out_col_r;

  logic              take;
  logic              col_last;
  logic              row_last;
  logic              wrap_row;
  logic              scroll_hit;
  logic              sweep_done;
  logic [SWP_W-1:0]  sweep_end;
  logic [SWP_W:0]    scroll_src;
  logic              load_out;
  logic [CELL_W-1:0] load_data;

  assign take       = ~q_empty & ~out_valid_r;
  assign col_last   = (col_r == COL_W'(COLUMNS - 1));
  assign row_last   = (row_r == ROW_W'(ROWS - 1));
  assign wrap_row   = ((cmd.kind == CMD_PUT) && col_last) || (cmd.kind == CMD_NEWLINE);
  assign scroll_hit = wrap_row & row_last;
  assign sweep_end  = zero_mode_r ? SWP_W'(CELL_COUNT - 1) : SWP_W'(CELL_COUNT);
  assign sweep_done = (sweep_r == sweep_end);
  assign scroll_src = {1'b0, sweep_r} + (SWP_W + 1)'(COLUMNS);

  assign status.init_done = init_done_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (take) begin
          if ((cmd.kind == CMD_CLEAR) || scroll_hit) begin
            state_nxt = BK_SWEEP;
          end else if (cmd.kind == CMD_READ) begin
            state_nxt = BK_READ;
          end
        end
      end
      BK_SWEEP: begin
        if (sweep_done) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_READ: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;
    load_out      = 1'b0;
    load_data     = '0;
    sweep_nxt     = sweep_r;
    zero_mode_nxt = zero_mode_r;
    report_nxt    = report_r;
    init_done_nxt = init_done_r;
    rd_ok_nxt     = rd_ok_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    base_nxt      = base_r;
    unique case (state_r)
      BK_IDLE: begin
        if (take) begin
          pop = 1'b1;
          unique case (cmd.kind)
            CMD_PUT, CMD_NEWLINE: begin
              if (cmd.kind == CMD_PUT) begin
                ram_we    = 1'b1;
                ram_waddr = base_r + ADDR_W'(col_r);
                ram_wdata = cmd.glyph;
                col_nxt   = col_r + 1'b1;
              end
              if (wrap_row) begin
                col_nxt = '0;
                if (row_last) begin
                  sweep_nxt     = '0;
                  zero_mode_nxt = 1'b0;
                  report_nxt    = 1'b1;
                end else begin
                  row_nxt  = row_r + 1'b1;
                  base_nxt = base_r + ADDR_W'(COLUMNS);
                  load_out = 1'b1;
                end
              end else begin
                load_out = 1'b1;
              end
            end
            CMD_RETURN: begin
              col_nxt  = '0;
              load_out = 1'b1;
            end
            CMD_CLEAR: begin
              row_nxt       = '0;
              col_nxt       = '0;
              base_nxt      = '0;
              sweep_nxt     = '0;
              zero_mode_nxt = 1'b1;
              report_nxt    = 1'b1;
            end
            CMD_READ: begin
              ram_raddr = cmd.index_ok ? cmd.index : '0;
              rd_ok_nxt = cmd.index_ok;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      BK_SWEEP: begin
        if (zero_mode_r) begin
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(sweep_r);
          ram_wdata = '0;
        end else begin
          if (scroll_src < (SWP_W + 1)'(CELL_COUNT)) begin
            ram_raddr = ADDR_W'(scroll_src);
          end
          if (sweep_r != '0) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(sweep_r - 1'b1);
            ram_wdata = (sweep_r <= SWP_W'(CELL_COUNT - COLUMNS)) ? ram_rdata : '0;
          end
        end
        if (sweep_done) begin
          sweep_nxt     = '0;
          init_done_nxt = 1'b1;
          load_out      = report_r;
          report_nxt    = 1'b0;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
        if (!zero_mode_r) begin
          row_nxt  = ROW_W'(ROWS - 1);
          base_nxt = ADDR_W'(CELL_COUNT - COLUMNS);
        end
      end
      BK_READ: begin
        load_out  = 1'b1;
        load_data = rd_ok_r ? ram_rdata : '0;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_SWEEP;
      sweep_r     <= '0;
      zero_mode_r <= 1'b1;
      report_r    <= 1'b0;
      init_done_r <= 1'b0;
      rd_ok_r     <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      zero_mode_r <= zero_mode_nxt;
      report_r    <= report_nxt;
      init_done_r <= init_done_nxt;
      rd_ok_r     <= rd_ok_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      base_r      <= base_nxt;
      out_valid_r <= (out_valid_r & ~out_txn.ready) | load_out;
    end
    if (load_out) begin
      out_data_r <= load_data;
      out_row_r  <= ROW_OUT_W'(32'(row_nxt));
      out_col_r  <= COL_OUT_W'(32'(col_nxt));
    end
  end

  assign out_txn.valid         = out_valid_r;
  assign out_txn.cell_data     = out_data_r;
  assign out_txn.cursor_row    = out_row_r;
  assign out_txn.cursor_column = out_col_r;

endmodule

// ===== rtl/text_mode_console_writer_core.sv =====
// Top level of the text-mode console writer: a screen of 80 x 25 cells with a cursor.
// After reset the screen memory is zeroed by a pass over all 2000 cells, during which no input
// transaction is accepted. The back end then issues one command and holds one result at a
// time, and a read goes through the registered read port of the single screen memory. A
// clear or a scroll (wrap or newline past the bottom row) passes over the memory one cell
// per cycle through its single write port. A two-entry command queue keeps accepting
// transactions, until it is full, while the back end works or a result waits.
module text_mode_console_writer_core (
  input  logic       clk,
  input  logic       rst_n,
  tmcw_in_if.sink    in_txn,
  tmcw_out_if.source out_txn
);
  import tmcw_pkg::*;

  back_status_t      status;
  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  cmd_t              push_cmd;
  cmd_t              pop_cmd;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  tmcw_front u_front (
    .in_txn   (in_txn),
    .status   (status),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  tmcw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  tmcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tmcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (pop_cmd),
    .q_empty   (q_empty),
    .pop       (pop),
    .status    (status),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_txn   (out_txn)
  );

endmodule

// ===== rtl/tmcw_checker.sv =====
// Port-level assertions for the console writer and their bind to the top level.
module tmcw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_cell_data,
  input logic [4:0]  out_cursor_row,
  input logic [6:0]  out_cursor_column
);
  import tmcw_pkg::*;

  a_init_blocks_input: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  a_cursor_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_cursor_row) < ROWS) && (32'(out_cursor_column) < COLUMNS))
    else $error("reported cursor outside the screen");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped before acceptance");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_cell_data) && $stable(out_cursor_row)
      && $stable(out_cursor_column))
    else $error("stalled result transaction changed");

endmodule

bind text_mode_console_writer_core tmcw_checker u_tmcw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_txn.ready),
  .out_valid         (out_txn.valid),
  .out_ready         (out_txn.ready),
  .out_cell_data     (out_txn.cell_data),
  .out_cursor_row    (out_txn.cursor_row),
  .out_cursor_column (out_txn.cursor_column)
);
